@@ src/tphc_pkg.sv @@
// shared types, latencies and helpers for the sensor compensation pipeline
package tphc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TEMP    = 3'd0,
    REG_PRESS_A = 3'd1,
    REG_PRESS_B = 3'd2,
    REG_PRESS_9 = 3'd3,
    REG_HUM_A   = 3'd4,
    REG_HUM_B   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [39:0] hum_b;
    logic [31:0] hum_a;
    logic [15:0] press_9;
    logic [63:0] press_b;
    logic [63:0] press_a;
    logic [47:0] temp;
  } cfg_t;

  localparam int MUL_LAT   = 2;
  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int TEMP_LAT  = 3;
  localparam int PRESS_LAT = 3 * MUL_LAT + 1 + DIV_LAT + 2 * MUL_LAT + 2;
  localparam int HUM_LAT   = 8;
  localparam int TOT_LAT   = TEMP_LAT + PRESS_LAT;

  function automatic logic signed [63:0] sx32to64(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic signed [63:0] sx16to64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic signed [31:0] sx16to32(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic signed [31:0] sx8to32(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

@@ src/tphc_mul64.sv @@
// two-stage 64x64 multiplier keeping the low 64 product bits
module tphc_mul64 (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_q;
  logic [31:0] lh_q;
  logic [31:0] hl_q;
  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    ll_q <= a_i[31:0] * b_i[31:0];
    lh_q <= a_i[31:0] * b_i[63:32];
    hl_q <= a_i[63:32] * b_i[31:0];
    p_q  <= ll_q + {lh_q + hl_q, 32'h0};
  end

  assign p_o = p_q;

endmodule

@@ src/tphc_sdiv.sv @@
// pipelined signed 64-bit divider, one quotient bit per stage, truncating
module tphc_sdiv
  import tphc_pkg::*;
(
  input  logic        clk_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic [63:0] quot_o
);

  logic [63:0] rem_q [DIV_STEPS+1];
  logic [63:0] aq_q  [DIV_STEPS+1];
  logic [63:0] dv_q  [DIV_STEPS+1];
  logic        ng_q  [DIV_STEPS+1];
  logic [63:0] rs_d  [DIV_STEPS];
  logic        ge_d  [DIV_STEPS];
  logic [63:0] quot_q;

  always_comb begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      rs_d[i] = {rem_q[i][62:0], aq_q[i][63]};
      ge_d[i] = rs_d[i] >= dv_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    aq_q[0]  <= num_i[63] ? -num_i : num_i;
    dv_q[0]  <= den_i[63] ? -den_i : den_i;
    ng_q[0]  <= num_i[63] ^ den_i[63];
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_q[i+1] <= ge_d[i] ? rs_d[i] - dv_q[i] : rs_d[i];
      aq_q[i+1]  <= {aq_q[i][62:0], ge_d[i]};
      dv_q[i+1]  <= dv_q[i];
      ng_q[i+1]  <= ng_q[i];
    end
    quot_q <= ng_q[DIV_STEPS] ? -aq_q[DIV_STEPS] : aq_q[DIV_STEPS];
  end

  assign quot_o = quot_q;

endmodule

@@ src/tphc_press.sv @@
// 64-bit pressure compensation pipeline with divider and saturation
module tphc_press
  import tphc_pkg::*;
(
  input  logic        clk_i,
  input  logic [31:0] tf_i,
  input  logic [19:0] adc_p_i,
  input  cfg_t        cfg_i,
  output logic [31:0] press_o,
  output logic        inv_o
);

  localparam int INV_DLY = PRESS_LAT - 3 * MUL_LAT - 2;

  logic [15:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign p1 = cfg_i.press_a[15:0];
  assign p2 = cfg_i.press_a[31:16];
  assign p3 = cfg_i.press_a[47:32];
  assign p4 = cfg_i.press_a[63:48];
  assign p5 = cfg_i.press_b[15:0];
  assign p6 = cfg_i.press_b[31:16];
  assign p7 = cfg_i.press_b[47:32];
  assign p8 = cfg_i.press_b[63:48];
  assign p9 = cfg_i.press_9;

  logic signed [63:0] v1_d;
  logic [63:0] sq, v1p5, v1p2, m4, m5, m6, m7, m8, m9, m10, quot;
  logic signed [63:0] e_q [2];
  logic signed [63:0] f_q [2];
  logic signed [63:0] m5s_d, v2_q, v1b_q;
  logic [63:0] praw_q [5];
  logic [63:0] num_d, m6a_d;
  logic signed [63:0] den_d, q_d;
  logic signed [63:0] q_q [2];
  logic signed [63:0] pd_q [4];
  logic signed [63:0] m10_q [2];
  logic signed [63:0] s9_d, s10_d, s_q, s8_d, r_d;
  logic inv_q [INV_DLY];
  logic [31:0] press_q;
  logic inv_o_q;

  assign v1_d = sx32to64(tf_i) - 64'sd128000;

  tphc_mul64 u_m1 (.clk_i, .a_i(v1_d), .b_i(v1_d), .p_o(sq));
  tphc_mul64 u_m2 (.clk_i, .a_i(v1_d), .b_i(sx16to64(p5)), .p_o(v1p5));
  tphc_mul64 u_m3 (.clk_i, .a_i(v1_d), .b_i(sx16to64(p2)), .p_o(v1p2));
  tphc_mul64 u_m4 (.clk_i, .a_i(sq), .b_i(sx16to64(p6)), .p_o(m4));
  tphc_mul64 u_m5 (.clk_i, .a_i(sq), .b_i(sx16to64(p3)), .p_o(m5));

  assign m5s_d = $signed(m5) >>> 8;
  assign m6a_d = 64'h0000_8000_0000_0000 + v1b_q;
  assign num_d = (praw_q[4] << 31) - v2_q;

  tphc_mul64 u_m6 (.clk_i, .a_i(m6a_d), .b_i({48'b0, p1}), .p_o(m6));
  tphc_mul64 u_m7 (.clk_i, .a_i(num_d), .b_i(64'd3125), .p_o(m7));

  assign den_d = $signed(m6) >>> 33;

  tphc_sdiv u_div (.clk_i, .num_i(m7), .den_i(den_d), .quot_o(quot));

  assign q_d = $signed(quot) >>> 13;

  tphc_mul64 u_m8  (.clk_i, .a_i(sx16to64(p9)), .b_i(q_d), .p_o(m8));
  tphc_mul64 u_m10 (.clk_i, .a_i(sx16to64(p8)), .b_i(quot), .p_o(m10));
  tphc_mul64 u_m9  (.clk_i, .a_i(m8), .b_i(q_q[1]), .p_o(m9));

  assign s9_d  = $signed(m9) >>> 25;
  assign s10_d = m10_q[1] >>> 19;
  assign s8_d  = s_q >>> 8;
  assign r_d   = s8_d + (sx16to64(p7) <<< 4);

  always_ff @(posedge clk_i) begin
    e_q[0]    <= $signed(v1p5 << 17) + (sx16to64(p4) <<< 35);
    e_q[1]    <= e_q[0];
    f_q[0]    <= $signed(v1p2 << 12);
    f_q[1]    <= f_q[0];
    v2_q      <= $signed(m4) + e_q[1];
    v1b_q     <= m5s_d + f_q[1];
    praw_q[0] <= {43'b0, 21'h10_0000 - {1'b0, adc_p_i}};
    for (int i = 1; i < 5; i++) praw_q[i] <= praw_q[i-1];
    inv_q[0]  <= den_d == 64'sd0;
    for (int i = 1; i < INV_DLY; i++) inv_q[i] <= inv_q[i-1];
    q_q[0]    <= q_d;
    q_q[1]    <= q_q[0];
    pd_q[0]   <= $signed(quot);
    for (int i = 1; i < 4; i++) pd_q[i] <= pd_q[i-1];
    m10_q[0]  <= $signed(m10);
    m10_q[1]  <= m10_q[0];
    s_q       <= pd_q[3] + s9_d + s10_d;
    inv_o_q   <= inv_q[INV_DLY-1];
    // out of range values saturate to the unsigned 32-bit limits; a zero divisor also forces zero
    if (inv_q[INV_DLY-1] || r_d[63]) begin
      press_q <= '0;
    end else if (|r_d[62:32]) begin
      press_q <= '1;
    end else begin
      press_q <= r_d[31:0];
    end
  end

  assign press_o = press_q;
  assign inv_o   = inv_o_q;

endmodule

@@ src/tphc_hum.sv @@
// 32-bit humidity compensation pipeline with clamp to 0..100 %RH
module tphc_hum
  import tphc_pkg::*;
(
  input  logic        clk_i,
  input  logic [31:0] tf_i,
  input  logic [15:0] adc_h_i,
  input  cfg_t        cfg_i,
  output logic [16:0] hum_o
);

  logic [7:0]  h1, h3, h6;
  logic [15:0] h2, h4, h5;
  assign h1 = cfg_i.hum_a[7:0];
  assign h2 = cfg_i.hum_a[23:8];
  assign h3 = cfg_i.hum_a[31:24];
  assign h4 = cfg_i.hum_b[15:0];
  assign h5 = cfg_i.hum_b[31:16];
  assign h6 = cfg_i.hum_b[39:32];

  logic signed [31:0] x_d, base_d;
  logic signed [31:0] base_q, hx5_q, xh6_q, xh3_q;
  logic signed [31:0] n_q, m1_q, m2_q, xh3s_d;
  logic signed [31:0] m3r_q, n3_q, m3_d;
  logic signed [31:0] m4r_q, n4_q, m4_d;
  logic signed [31:0] xq_q, a_d, aa_q, x6_q, b_d, bh1_q, x7_q, c_d, y_d;
  logic [16:0] hum_q;

  assign x_d    = $signed(tf_i) - 32'sd76800;
  assign base_d = $signed((32'(adc_h_i) << 14) - (sx16to32(h4) <<< 20) + 32'sd16384);
  assign xh3s_d = xh3_q >>> 11;
  assign m3_d   = m3r_q >>> 10;
  assign m4_d   = (m4r_q + 32'sd8192) >>> 14;
  assign a_d    = xq_q >>> 15;
  assign b_d    = aa_q >>> 7;
  assign c_d    = bh1_q >>> 4;
  assign y_d    = x7_q - c_d;

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    hx5_q  <= sx16to32(h5) * x_d;
    xh6_q  <= x_d * sx8to32(h6);
    xh3_q  <= x_d * $signed({24'b0, h3});
    n_q    <= (base_q - hx5_q) >>> 15;
    m1_q   <= xh6_q >>> 10;
    m2_q   <= xh3s_d + 32'sd32768;
    m3r_q  <= m1_q * m2_q;
    n3_q   <= n_q;
    m4r_q  <= (m3_d + 32'sd2097152) * sx16to32(h2);
    n4_q   <= n3_q;
    xq_q   <= n4_q * m4_d;
    aa_q   <= a_d * a_d;
    x6_q   <= xq_q;
    bh1_q  <= b_d * $signed({24'b0, h1});
    x7_q   <= x6_q;
    if (y_d < 32'sd0) begin
      hum_q <= '0;
    end else if (y_d > 32'sd419430400) begin
      hum_q <= 17'd102400;
    end else begin
      hum_q <= y_d[28:12];
    end
  end

  assign hum_o = hum_q;

endmodule

@@ src/temp_press_hum_compensation_core.sv @@
// top level: config registers, temperature stages, result alignment
//
//  channel   handshake                    payload
//  input     start_i, busy_o              raw_pressure_i, raw_temperature_i, raw_humidity_i
//  config    cfg_valid_i, cfg_ready_o     cfg_index_i, cfg_data_i
//  result    out_valid_o (strobe)         fine_temperature_o, pressure_q24_8_o,
//                                         pressure_invalid_o, humidity_q22_10_o
//
// one reading enters per cycle; busy_o stays low
// a result strobes once the pressure path, the longest, has finished with it
// (ten 64-bit multipliers around a 66-stage one-bit-per-step divider)
// reset clears the valid line and the coefficients; the pipeline never stalls
module temp_press_hum_compensation_core
  import tphc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [19:0] raw_pressure_i,
  input  logic [19:0] raw_temperature_i,
  input  logic [15:0] raw_humidity_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        out_valid_o,
  output logic signed [31:0] fine_temperature_o,
  output logic [31:0] pressure_q24_8_o,
  output logic        pressure_invalid_o,
  output logic [16:0] humidity_q22_10_o
);

  localparam int HUM_DLY = PRESS_LAT - HUM_LAT;

  cfg_t cfg_q;
  logic vld_q [TOT_LAT+1];
  logic [19:0] adct_q;
  logic [19:0] adcp_q [TEMP_LAT+1];
  logic [15:0] adch_q [TEMP_LAT+1];

  logic [15:0] t1, t2, t3;
  logic signed [31:0] a_d, b_d, at2_q, bb_q, bbs_d, v1t_q, bt3_q, bt3s_d, tf_q;
  logic [31:0] tf_dl_q [PRESS_LAT];
  logic [16:0] hum, hum_dl_q [HUM_DLY];
  logic [31:0] press;
  logic inv;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TEMP:    cfg_q.temp    <= cfg_data_i[47:0];
        REG_PRESS_A: cfg_q.press_a <= cfg_data_i;
        REG_PRESS_B: cfg_q.press_b <= cfg_data_i;
        REG_PRESS_9: cfg_q.press_9 <= cfg_data_i[15:0];
        REG_HUM_A:   cfg_q.hum_a   <= cfg_data_i[31:0];
        REG_HUM_B:   cfg_q.hum_b   <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= TOT_LAT; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= start_i;
      for (int i = 1; i <= TOT_LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  assign t1 = cfg_q.temp[15:0];
  assign t2 = cfg_q.temp[31:16];
  assign t3 = cfg_q.temp[47:32];

  assign a_d    = $signed(32'(adct_q[19:3]) - 32'({t1, 1'b0}));
  assign b_d    = $signed(32'(adct_q[19:4]) - 32'(t1));
  assign bbs_d  = bb_q >>> 12;
  assign bt3s_d = bt3_q >>> 14;

  always_ff @(posedge clk_i) begin
    adct_q    <= raw_temperature_i;
    adcp_q[0] <= raw_pressure_i;
    adch_q[0] <= raw_humidity_i;
    for (int i = 1; i <= TEMP_LAT; i++) begin
      adcp_q[i] <= adcp_q[i-1];
      adch_q[i] <= adch_q[i-1];
    end
    at2_q <= a_d * sx16to32(t2);
    bb_q  <= b_d * b_d;
    v1t_q <= at2_q >>> 11;
    bt3_q <= bbs_d * sx16to32(t3);
    tf_q  <= v1t_q + bt3s_d;
    tf_dl_q[0]  <= tf_q;
    for (int i = 1; i < PRESS_LAT; i++) tf_dl_q[i] <= tf_dl_q[i-1];
    hum_dl_q[0] <= hum;
    for (int i = 1; i < HUM_DLY; i++) hum_dl_q[i] <= hum_dl_q[i-1];
  end

  tphc_press u_press (
    .clk_i,
    .tf_i    (tf_q),
    .adc_p_i (adcp_q[TEMP_LAT]),
    .cfg_i   (cfg_q),
    .press_o (press),
    .inv_o   (inv)
  );

  tphc_hum u_hum (
    .clk_i,
    .tf_i    (tf_q),
    .adc_h_i (adch_q[TEMP_LAT]),
    .cfg_i   (cfg_q),
    .hum_o   (hum)
  );

  assign out_valid_o        = vld_q[TOT_LAT];
  assign fine_temperature_o = $signed(tf_dl_q[PRESS_LAT-1]);
  assign pressure_q24_8_o   = press;
  assign pressure_invalid_o = inv;
  assign humidity_q22_10_o  = hum_dl_q[HUM_DLY-1];

endmodule
